@@ hdl/cbm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types for the cartridge bank mapper.
package cbm_pkg;

	localparam int CHR_WINDOWS   = 8;
	localparam int PRG_PAGE_BITS = 6;

	// page store: CHR windows at 0..7, PRG windows at 8..10
	localparam int PAGE_ENTRIES = 16;
	localparam int PAGE_IDX_W   = $clog2(PAGE_ENTRIES);
	localparam int PAGE_W       = 8;

	localparam logic [7:0] CHR_RAM_MASK = 8'h1f;
	localparam logic [7:0] PRG_DATA_MASK = 8'h3f;

	typedef enum logic [1:0] {
		REQ_CPU_RD = 2'd0,
		REQ_CPU_WR = 2'd1,
		REQ_PPU    = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_ROM = 3'd1,
		TGT_PRG_RAM = 3'd2,
		TGT_CHR_ROM = 3'd3,
		TGT_CHR_RAM = 3'd4,
		TGT_NT_INT  = 3'd5,
		TGT_NT_FOUR = 3'd6
	} target_t;

	typedef enum logic [1:0] {
		MIR_SINGLE_A = 2'd0,
		MIR_VERT     = 2'd1,
		MIR_SINGLE_B = 2'd2,
		MIR_HORIZ    = 2'd3
	} mirror_t;

	typedef enum logic [1:0] {
		REG_PRG_MASK   = 2'd0,
		REG_CHR_MASK   = 2'd1,
		REG_CHR_IS_RAM = 2'd2,
		REG_HDR_MIRROR = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                  en;
		logic [PAGE_IDX_W-1:0] idx;
		logic [PAGE_W-1:0]     data;
	} page_wr_t;

	typedef struct packed {
		logic                  en;
		logic [PAGE_IDX_W-1:0] idx;
	} page_rd_t;

	// page held by an entry that was never written since reset
	function automatic logic [PAGE_W-1:0] page_reset_value(input logic [PAGE_IDX_W-1:0] idx);
		logic [PAGE_W-1:0] v;
		if (idx[3])
			v = {6'd0, idx[1:0]};
		else
			v = {5'd0, idx[2:0]};
		return v;
	endfunction

endpackage

@@ hdl/cbm_page_store.sv @@
`timescale 1ns / 1ps
// Page register store: synchronous RAM with per-entry valid bits and reset values.
module cbm_page_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cbm_pkg::page_rd_t              rd,
	input  cbm_pkg::page_wr_t              wr,
	output logic [cbm_pkg::PAGE_W-1:0]     rd_data
);

	logic [cbm_pkg::PAGE_W-1:0]       mem [cbm_pkg::PAGE_ENTRIES];
	logic [cbm_pkg::PAGE_ENTRIES-1:0] valid_q;
	logic [cbm_pkg::PAGE_W-1:0]       rd_raw_q;
	logic [cbm_pkg::PAGE_IDX_W-1:0]   rd_idx_q;
	logic                             rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.idx] <= wr.data;
		if (rd.en) begin
			rd_raw_q <= mem[rd.idx];
			rd_idx_q <= rd.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr.en)
				valid_q[wr.idx] <= 1'b1;
			if (rd.en)
				rd_hit_q <= valid_q[rd.idx];
		end
	end

	assign rd_data = rd_hit_q ? rd_raw_q : cbm_pkg::page_reset_value(rd_idx_q);

endmodule

@@ hdl/cartridge_bank_mapper.sv @@
`timescale 1ns / 1ps
// Cartridge bank mapper top level: bus access translation and bank register writes.
// Each transaction reads its page register from the page store (synchronous RAM) on the
// edge that accepts it; when s1 advances to the output register, the target and mapped
// address are formed into that register and a bank write writes back a page.
// A new transaction is taken once the previous one has reached the output register,
// even while that result still waits there for out_ready.
// Page registers come up at their power-on values via per-entry valid bits; no
// clearing pass is needed. Configuration writes land on the edge that samples wr_en.
module cartridge_bank_mapper #(
	parameter int PRG_PAGE_BITS = cbm_pkg::PRG_PAGE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] bus_addr,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  target,
	output logic [18:0] mapped_addr
);

	localparam logic [5:0] PRG_WR_MASK = 6'((1 << PRG_PAGE_BITS) - 1);

	// configuration
	logic [5:0] prg_page_mask_q;
	logic [7:0] chr_page_mask_q;
	logic       chr_is_ram_q;
	logic [1:0] header_mirror_q;
	logic [1:0] mirror_q;

	// item in flight
	logic        s1_valid;
	logic [1:0]  req_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic                       accept;
	logic                       s1_go;
	cbm_pkg::page_rd_t          pg_rd;
	cbm_pkg::page_wr_t          pg_wr;
	logic [cbm_pkg::PAGE_W-1:0] pg_data;

	logic        out_valid_q;
	logic [2:0]  target_q;
	logic [18:0] mapped_addr_q;

	logic [2:0]  tgt_d;
	logic [18:0] maddr_d;
	logic [5:0]  prg_page;
	logic [7:0]  chr_page;
	logic [13:0] ppu_a;
	logic        phys;
	logic        is_bank_wr;
	logic        mirror_wr;

	assign in_ready = !s1_valid;
	assign accept   = in_valid && in_ready;
	assign s1_go    = s1_valid && (!out_valid_q || out_ready);

	// PPU requests read a CHR window, all other requests read a PRG window
	always_comb begin
		pg_rd.en = accept;
		if (req_type == cbm_pkg::REQ_PPU)
			pg_rd.idx = {1'b0, bus_addr[12:10]};
		else
			pg_rd.idx = {2'b10, bus_addr[14:13]};
	end

	cbm_page_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (pg_rd),
		.wr      (pg_wr),
		.rd_data (pg_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_page_mask_q <= 6'h3f;
			chr_page_mask_q <= 8'hff;
			chr_is_ram_q    <= 1'b0;
			header_mirror_q <= 2'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				cbm_pkg::REG_PRG_MASK:   prg_page_mask_q <= wr_data[5:0];
				cbm_pkg::REG_CHR_MASK:   chr_page_mask_q <= wr_data;
				cbm_pkg::REG_CHR_IS_RAM: chr_is_ram_q    <= wr_data[0];
				cbm_pkg::REG_HDR_MIRROR: header_mirror_q <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	assign is_bank_wr = (req_s1 == cbm_pkg::REQ_CPU_WR) && addr_s1[15];
	assign mirror_wr  = s1_go && is_bank_wr && (addr_s1[15:11] == 5'b11100)
		&& !header_mirror_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mirror_q <= cbm_pkg::MIR_HORIZ;
		else if (wr_en && wr_index == cbm_pkg::REG_HDR_MIRROR)
			mirror_q <= (wr_data[1:0] == 2'd1) ? cbm_pkg::MIR_VERT : cbm_pkg::MIR_HORIZ;
		else if (mirror_wr)
			mirror_q <= data_s1[7:6];
	end

	// bank register write-back
	always_comb begin
		pg_wr.en   = 1'b0;
		pg_wr.idx  = {1'b0, addr_s1[13:11]};
		pg_wr.data = chr_is_ram_q ? (data_s1 & cbm_pkg::CHR_RAM_MASK) : data_s1;
		if (s1_go && is_bank_wr) begin
			if (!addr_s1[14]) begin
				pg_wr.en = 1'b1;
			end else if (addr_s1[13] && addr_s1[12:11] != 2'b11) begin
				pg_wr.en   = 1'b1;
				pg_wr.idx  = {2'b10, addr_s1[12:11]};
				pg_wr.data = data_s1 & cbm_pkg::PRG_DATA_MASK & {2'b00, PRG_WR_MASK};
			end
		end
	end

	// result formation
	always_comb begin
		tgt_d    = cbm_pkg::TGT_NONE;
		maddr_d  = '0;
		ppu_a    = addr_s1[13:0];
		prg_page = ((addr_s1[14:13] == 2'b11) ? prg_page_mask_q : pg_data[5:0])
			& prg_page_mask_q & PRG_WR_MASK;
		chr_page = pg_data & chr_page_mask_q;
		case (mirror_q)
			cbm_pkg::MIR_SINGLE_A: phys = 1'b0;
			cbm_pkg::MIR_VERT:     phys = ppu_a[10];
			cbm_pkg::MIR_SINGLE_B: phys = 1'b1;
			default:               phys = ppu_a[11];
		endcase
		case (req_s1) inside
			cbm_pkg::REQ_CPU_RD, cbm_pkg::REQ_CPU_WR: begin
				if (addr_s1[15]) begin
					if (req_s1 == cbm_pkg::REQ_CPU_RD) begin
						tgt_d   = cbm_pkg::TGT_PRG_ROM;
						maddr_d = {prg_page, addr_s1[12:0]};
					end
				end else if (addr_s1[14:13] == 2'b11) begin
					tgt_d   = cbm_pkg::TGT_PRG_RAM;
					maddr_d = {6'd0, addr_s1[12:0]};
				end
			end
			cbm_pkg::REQ_PPU: begin
				if (!ppu_a[13]) begin
					tgt_d   = chr_is_ram_q ? cbm_pkg::TGT_CHR_RAM : cbm_pkg::TGT_CHR_ROM;
					maddr_d = {1'b0, chr_page, ppu_a[9:0]};
				end else if (ppu_a[13:8] != 6'h3f) begin
					if (header_mirror_q[1]) begin
						tgt_d   = cbm_pkg::TGT_NT_FOUR;
						maddr_d = {7'd0, ppu_a[11:0]};
					end else begin
						tgt_d   = cbm_pkg::TGT_NT_INT;
						maddr_d = {8'd0, phys, ppu_a[9:0]};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			addr_s1 <= bus_addr;
			data_s1 <= write_data;
		end
		if (s1_go) begin
			target_q      <= tgt_d;
			mapped_addr_q <= maddr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				s1_valid <= 1'b1;
			else if (s1_go)
				s1_valid <= 1'b0;
			if (s1_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign target      = target_q;
	assign mapped_addr = mapped_addr_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid)
		else $error("accepted transaction not held in s1");

	a_s1_lands_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> out_valid_q && !s1_valid)
		else $error("s1 result did not reach output register");

	a_none_has_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && target_q == cbm_pkg::TGT_NONE) |-> mapped_addr_q == 19'd0)
		else $error("target none with nonzero address");

	a_store_write_on_go: assert property (@(posedge clk) disable iff (!arst_n)
		pg_wr.en |-> (s1_go && !pg_rd.en))
		else $error("page store write outside completion or colliding with read");

endmodule
